// ===== hw/rtl/uvs_pkg.sv =====
`default_nettype none
package uvs_pkg;

    // quotient bits of the phase divider: a longitude phase reaches 2^32
    localparam int QBITS = 33;
    // CORDIC datapath width, Q2.30 plus guard bits
    localparam int XW = 34;
    localparam int CORDIC_TABLE_LEN = 24;

    localparam logic signed [XW-1:0] CORDIC_GAIN = 34'sd652032874;

    // arctangent of 2^-i as a fraction of a full turn (2^32 = 360 degrees)
    localparam logic [31:0] ATAN_TURN [CORDIC_TABLE_LEN] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
        32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
        32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
        32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
        32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
    };

    typedef enum logic [1:0] {
        REG_RADIUS  = 2'd0,
        REG_LAT     = 2'd1,
        REG_LON     = 2'd2,
        REG_UNUSED  = 2'd3
    } cfg_reg_t;

    // one rotation lane: vector, residual angle and the folded quadrant
    typedef struct packed {
        logic signed [XW-1:0] x;
        logic signed [XW-1:0] y;
        logic signed [XW-1:0] z;
        logic [1:0]           q;
    } cordic_lane_t;

    function automatic logic signed [15:0] sat_norm(input logic signed [63:0] v);
        logic signed [15:0] r;
        if (v > 64'sd16384) begin
            r = 16'sd16384;
        end else if (v < -64'sd16384) begin
            r = -16'sd16384;
        end else begin
            r = v[15:0];
        end
        return r;
    endfunction

    function automatic logic signed [15:0] sat_pos(input logic signed [63:0] v);
        logic signed [15:0] r;
        if (v > 64'sd32767) begin
            r = 16'sh7FFF;
        end else if (v < -64'sd32768) begin
            r = 16'sh8000;
        end else begin
            r = v[15:0];
        end
        return r;
    endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/uv_sphere_vertex_generator.sv =====
`default_nettype none
// Pipeline: 1 clamp, 33 divider cells, 1 fold, CORDIC_STAGES rotation cells and 3 scale
// registers lie between an input beat and its result beat.
// Throughput: one beat per cycle; the whole cell chain advances together and
// holds while a result beat waits on the output register.
// Reset: synchronous, active low; clears all valid bits and loads radius 1.0,
// 8 latitude bands and 8 longitude segments.
module uv_sphere_vertex_generator import uvs_pkg::*; #(
    parameter int GRID_BITS     = 10,
    parameter int CORDIC_STAGES = 16
) (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            cfg_we,
    input  wire logic [1:0]                      cfg_index,
    input  wire logic [15:0]                     cfg_wdata,
    input  wire logic                            s_tvalid,
    output logic                                 s_tready,
    // row_index, col_index, zero fill
    input  wire logic [((2*GRID_BITS+7)/8)*8-1:0] s_tdata,
    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    // pos_x, pos_y, pos_z, normal_x, normal_y, normal_z
    output logic [95:0]                          m_tdata,
    // index_clamped
    output logic [0:0]                           m_tuser
);

    localparam int DW = GRID_BITS + QBITS;

    logic [15:0] radius_reg;
    logic [9:0]  lat_steps_reg, lon_steps_reg;

    // register writes; unknown indexes drop
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            radius_reg    <= 16'd256;
            lat_steps_reg <= 10'd8;
            lon_steps_reg <= 10'd8;
        end else if (cfg_we) begin
            case (cfg_reg_t'(cfg_index))
                REG_RADIUS: radius_reg    <= cfg_wdata;
                REG_LAT:    lat_steps_reg <= cfg_wdata[9:0];
                REG_LON:    lon_steps_reg <= cfg_wdata[9:0];
                default: ;
            endcase
        end
    end

    // the whole chain moves when the output register is free or drained
    logic en;
    logic out_valid;
    assign en       = !out_valid || m_tready;
    assign s_tready = en;

    // grid counts in GRID_BITS bits, a zero count counts as one
    logic [31:0]          lat_wide, lon_wide;
    logic [GRID_BITS-1:0] rows_g, cols_g, row_in, col_in, row_c, col_c;
    logic                 flag_c;
    logic [DW-1:0]        div_lat, div_lon;

    always_comb begin
        lat_wide = 32'(lat_steps_reg);
        lon_wide = 32'(lon_steps_reg);
        rows_g = (lat_wide[GRID_BITS-1:0] == '0) ? GRID_BITS'(1) : lat_wide[GRID_BITS-1:0];
        cols_g = (lon_wide[GRID_BITS-1:0] == '0) ? GRID_BITS'(1) : lon_wide[GRID_BITS-1:0];
        row_in = s_tdata[GRID_BITS-1:0];
        col_in = s_tdata[2*GRID_BITS-1:GRID_BITS];
        row_c  = (row_in > rows_g) ? rows_g : row_in;
        col_c  = (col_in > cols_g) ? cols_g : col_in;
        flag_c = (row_in > rows_g) || (col_in > cols_g);
        // round to nearest: add half the divisor before dividing
        div_lat = (DW'(row_c) << 31) + DW'(rows_g >> 1);
        div_lon = (DW'(col_c) << 32) + DW'(cols_g >> 1);
    end

    logic                 dv_valid [0:QBITS];
    logic                 dv_flag  [0:QBITS];
    logic [GRID_BITS-1:0] rem_lat  [0:QBITS];
    logic [GRID_BITS-1:0] rem_lon  [0:QBITS];
    logic [QBITS-1:0]     word_lat [0:QBITS];
    logic [QBITS-1:0]     word_lon [0:QBITS];

    logic                 in_valid_reg, in_flag_reg;
    logic [DW-1:0]        in_lat_reg, in_lon_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (en) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            in_flag_reg <= flag_c;
            in_lat_reg  <= div_lat;
            in_lon_reg  <= div_lon;
        end
    end

    // high bits seed the remainder, low bits shift through as the quotient
    assign dv_valid[0] = in_valid_reg;
    assign dv_flag[0]  = in_flag_reg;
    assign rem_lat[0]  = in_lat_reg[DW-1:QBITS];
    assign rem_lon[0]  = in_lon_reg[DW-1:QBITS];
    assign word_lat[0] = in_lat_reg[QBITS-1:0];
    assign word_lon[0] = in_lon_reg[QBITS-1:0];

    for (genvar i = 0; i < QBITS; i++) begin : g_div
        uvs_div_cell #(.GRID_BITS(GRID_BITS)) u_cell (
            .aclk         (aclk),
            .aresetn      (aresetn),
            .en           (en),
            .valid_in     (dv_valid[i]),
            .flag_in      (dv_flag[i]),
            .d_lat        (rows_g),
            .d_lon        (cols_g),
            .rem_lat_in   (rem_lat[i]),
            .word_lat_in  (word_lat[i]),
            .rem_lon_in   (rem_lon[i]),
            .word_lon_in  (word_lon[i]),
            .valid_out    (dv_valid[i+1]),
            .flag_out     (dv_flag[i+1]),
            .rem_lat_out  (rem_lat[i+1]),
            .word_lat_out (word_lat[i+1]),
            .rem_lon_out  (rem_lon[i+1]),
            .word_lon_out (word_lon[i+1])
        );
    end

    // fold a turn phase to the nearest quadrant, residual within +-45 degrees
    function automatic cordic_lane_t fold(input logic [31:0] phase);
        cordic_lane_t r;
        logic [31:0] t, d;
        t = phase + 32'h2000_0000;
        d = phase - {t[31:30], 30'd0};
        r.q = t[31:30];
        r.x = CORDIC_GAIN;
        r.y = '0;
        r.z = XW'($signed(d));
        return r;
    endfunction

    logic [31:0]  lat_phase, lon_phase;
    assign lat_phase = 32'hC000_0000 + word_lat[QBITS][31:0];
    assign lon_phase = word_lon[QBITS][31:0];

    logic         cr_valid [0:CORDIC_STAGES];
    logic         cr_flag  [0:CORDIC_STAGES];
    cordic_lane_t cr_lat   [0:CORDIC_STAGES];
    cordic_lane_t cr_lon   [0:CORDIC_STAGES];

    logic         fold_valid_reg, fold_flag_reg;
    cordic_lane_t fold_lat_reg, fold_lon_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fold_valid_reg <= 1'b0;
        end else if (en) begin
            fold_valid_reg <= dv_valid[QBITS];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            fold_flag_reg <= dv_flag[QBITS];
            fold_lat_reg  <= fold(lat_phase);
            fold_lon_reg  <= fold(lon_phase);
        end
    end

    assign cr_valid[0] = fold_valid_reg;
    assign cr_flag[0]  = fold_flag_reg;
    assign cr_lat[0]   = fold_lat_reg;
    assign cr_lon[0]   = fold_lon_reg;

    for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_cordic
        uvs_cordic_cell #(.STAGE(i)) u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .en        (en),
            .valid_in  (cr_valid[i]),
            .flag_in   (cr_flag[i]),
            .lat_in    (cr_lat[i]),
            .lon_in    (cr_lon[i]),
            .valid_out (cr_valid[i+1]),
            .flag_out  (cr_flag[i+1]),
            .lat_out   (cr_lat[i+1]),
            .lon_out   (cr_lon[i+1])
        );
    end

    // restore quadrants, form direction, round and scale by the radius
    uvs_project u_project (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .en       (en),
        .valid_in (cr_valid[CORDIC_STAGES]),
        .flag_in  (cr_flag[CORDIC_STAGES]),
        .lat_in   (cr_lat[CORDIC_STAGES]),
        .lon_in   (cr_lon[CORDIC_STAGES]),
        .radius   (radius_reg),
        .m_valid  (out_valid),
        .m_data   (m_tdata),
        .m_flag   (m_tuser[0])
    );

    assign m_tvalid = out_valid;

endmodule
`default_nettype wire

// ===== hw/rtl/uvs_div_cell.sv =====
`default_nettype none
module uvs_div_cell import uvs_pkg::*; #(
    parameter int GRID_BITS = 10
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 en,
    input  wire logic                 valid_in,
    input  wire logic                 flag_in,
    input  wire logic [GRID_BITS-1:0] d_lat,
    input  wire logic [GRID_BITS-1:0] d_lon,
    input  wire logic [GRID_BITS-1:0] rem_lat_in,
    input  wire logic [QBITS-1:0]     word_lat_in,
    input  wire logic [GRID_BITS-1:0] rem_lon_in,
    input  wire logic [QBITS-1:0]     word_lon_in,
    output logic                      valid_out,
    output logic                      flag_out,
    output logic [GRID_BITS-1:0]      rem_lat_out,
    output logic [QBITS-1:0]          word_lat_out,
    output logic [GRID_BITS-1:0]      rem_lon_out,
    output logic [QBITS-1:0]          word_lon_out
);

    logic [GRID_BITS:0]   t_lat, t_lon, s_lat, s_lon;
    logic                 ge_lat, ge_lon;
    logic [GRID_BITS-1:0] rem_lat_next, rem_lon_next;
    logic [QBITS-1:0]     word_lat_next, word_lon_next;
    logic                 valid_reg, flag_reg;
    logic [GRID_BITS-1:0] rem_lat_reg, rem_lon_reg;
    logic [QBITS-1:0]     word_lat_reg, word_lon_reg;

    // shift in the next dividend bit, subtract the divisor where it fits
    always_comb begin
        t_lat = {rem_lat_in, word_lat_in[QBITS-1]};
        t_lon = {rem_lon_in, word_lon_in[QBITS-1]};
        ge_lat = (t_lat >= {1'b0, d_lat});
        ge_lon = (t_lon >= {1'b0, d_lon});
        s_lat = t_lat - {1'b0, d_lat};
        s_lon = t_lon - {1'b0, d_lon};
        rem_lat_next = ge_lat ? s_lat[GRID_BITS-1:0] : t_lat[GRID_BITS-1:0];
        rem_lon_next = ge_lon ? s_lon[GRID_BITS-1:0] : t_lon[GRID_BITS-1:0];
        word_lat_next = {word_lat_in[QBITS-2:0], ge_lat};
        word_lon_next = {word_lon_in[QBITS-2:0], ge_lon};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg <= valid_in;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            flag_reg     <= flag_in;
            rem_lat_reg  <= rem_lat_next;
            rem_lon_reg  <= rem_lon_next;
            word_lat_reg <= word_lat_next;
            word_lon_reg <= word_lon_next;
        end
    end

    assign valid_out    = valid_reg;
    assign flag_out     = flag_reg;
    assign rem_lat_out  = rem_lat_reg;
    assign rem_lon_out  = rem_lon_reg;
    assign word_lat_out = word_lat_reg;
    assign word_lon_out = word_lon_reg;

endmodule
`default_nettype wire

// ===== hw/rtl/uvs_cordic_cell.sv =====
`default_nettype none
module uvs_cordic_cell import uvs_pkg::*; #(
    parameter int STAGE = 0
) (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         en,
    input  wire logic         valid_in,
    input  wire logic         flag_in,
    input  wire cordic_lane_t lat_in,
    input  wire cordic_lane_t lon_in,
    output logic              valid_out,
    output logic              flag_out,
    output cordic_lane_t      lat_out,
    output cordic_lane_t      lon_out
);

    localparam logic signed [XW-1:0] ATAN = XW'(ATAN_TURN[STAGE]);

    logic         valid_reg, flag_reg;
    cordic_lane_t lat_reg, lon_reg, lat_next, lon_next;

    function automatic cordic_lane_t rotate(input cordic_lane_t a);
        cordic_lane_t r;
        logic signed [XW-1:0] xs, ys;
        xs = a.x >>> STAGE;
        ys = a.y >>> STAGE;
        r.q = a.q;
        if (!a.z[XW-1]) begin
            r.x = a.x - ys;
            r.y = a.y + xs;
            r.z = a.z - ATAN;
        end else begin
            r.x = a.x + ys;
            r.y = a.y - xs;
            r.z = a.z + ATAN;
        end
        return r;
    endfunction

    always_comb begin
        lat_next = rotate(lat_in);
        lon_next = rotate(lon_in);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg <= valid_in;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            flag_reg <= flag_in;
            lat_reg  <= lat_next;
            lon_reg  <= lon_next;
        end
    end

    assign valid_out = valid_reg;
    assign flag_out  = flag_reg;
    assign lat_out   = lat_reg;
    assign lon_out   = lon_reg;

endmodule
`default_nettype wire

// ===== hw/rtl/uvs_project.sv =====
`default_nettype none
module uvs_project import uvs_pkg::*; (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         en,
    input  wire logic         valid_in,
    input  wire logic         flag_in,
    input  wire cordic_lane_t lat_in,
    input  wire cordic_lane_t lon_in,
    input  wire logic [15:0]  radius,
    output logic              m_valid,
    output logic [95:0]       m_data,
    output logic              m_flag
);

    logic signed [31:0] cl, sl, co, so;
    logic signed [63:0] px, pz;

    logic               a_valid_reg, a_flag_reg;
    logic signed [63:0] a_dx_reg, a_dz_reg;
    logic signed [31:0] a_sl_reg;

    logic signed [63:0] tnx, tnz, trx, trz;
    logic signed [31:0] tny;
    logic               b_valid_reg, b_flag_reg;
    logic signed [15:0] b_nx_reg, b_ny_reg, b_nz_reg;
    logic signed [33:0] b_dx_reg, b_dy_reg, b_dz_reg;

    logic signed [50:0] mx, my, mz, rx, ry, rz;
    logic               c_valid_reg, c_flag_reg;
    logic [95:0]        c_data_reg;

    // undo the quadrant fold by exact swaps and negations
    function automatic logic [63:0] restore(input cordic_lane_t a);
        logic signed [XW-1:0] c, s;
        case (a.q)
            2'd0: begin c = a.x;  s = a.y;  end
            2'd1: begin c = -a.y; s = a.x;  end
            2'd2: begin c = -a.x; s = -a.y; end
            default: begin c = a.y; s = -a.x; end
        endcase
        return {c[31:0], s[31:0]};
    endfunction

    always_comb begin
        {cl, sl} = restore(lat_in);
        {co, so} = restore(lon_in);
        px = cl * so;
        pz = cl * co;
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            a_flag_reg <= flag_in;
            a_dx_reg   <= -px;
            a_dz_reg   <= -pz;
            a_sl_reg   <= sl;
        end
    end

    // round the Q4.60 direction to Q1.14 normals and to Q2.30 for scaling
    always_comb begin
        tnx = (a_dx_reg + 64'sh0000_2000_0000_0000) >>> 46;
        tnz = (a_dz_reg + 64'sh0000_2000_0000_0000) >>> 46;
        tny = (a_sl_reg + 32'sh0000_8000) >>> 16;
        trx = (a_dx_reg + 64'sh0000_0000_2000_0000) >>> 30;
        trz = (a_dz_reg + 64'sh0000_0000_2000_0000) >>> 30;
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            b_flag_reg <= a_flag_reg;
            b_nx_reg   <= sat_norm(tnx);
            b_ny_reg   <= sat_norm(64'(tny));
            b_nz_reg   <= sat_norm(tnz);
            b_dx_reg   <= trx[33:0];
            b_dy_reg   <= 34'(a_sl_reg);
            b_dz_reg   <= trz[33:0];
        end
    end

    // scale by the radius, round to Q8.8
    always_comb begin
        mx = b_dx_reg * $signed({1'b0, radius});
        my = b_dy_reg * $signed({1'b0, radius});
        mz = b_dz_reg * $signed({1'b0, radius});
        rx = (mx + 51'sh2000_0000) >>> 30;
        ry = (my + 51'sh2000_0000) >>> 30;
        rz = (mz + 51'sh2000_0000) >>> 30;
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            c_flag_reg <= b_flag_reg;
            c_data_reg <= {b_nz_reg, b_ny_reg, b_nx_reg,
                           sat_pos(64'(rz)), sat_pos(64'(ry)), sat_pos(64'(rx))};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            c_valid_reg <= 1'b0;
        end else if (en) begin
            a_valid_reg <= valid_in;
            b_valid_reg <= a_valid_reg;
            c_valid_reg <= b_valid_reg;
        end
    end

    assign m_valid = c_valid_reg;
    assign m_data  = c_data_reg;
    assign m_flag  = c_flag_reg;

endmodule
`default_nettype wire

// ===== hw/rtl/uvs_checker.sv =====
`default_nettype none
module uvs_checker (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        s_tready,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [95:0] m_tdata
);

    // a result beat that is not taken stays offered
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result beat dropped while stalled");

    // the input side stalls exactly when a result waits
    a_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tready == (!m_tvalid || m_tready))
        else $error("input ready does not follow output stall");

    // each normal component stays within +-1.0 in Q1.14
    a_norm: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> ($signed(m_tdata[63:48]) <= 16'sd16384 &&
                      $signed(m_tdata[63:48]) >= -16'sd16384 &&
                      $signed(m_tdata[79:64]) <= 16'sd16384 &&
                      $signed(m_tdata[79:64]) >= -16'sd16384 &&
                      $signed(m_tdata[95:80]) <= 16'sd16384 &&
                      $signed(m_tdata[95:80]) >= -16'sd16384))
        else $error("normal component out of range");

    // reset empties the chain
    a_reset: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

endmodule

bind uv_sphere_vertex_generator uvs_checker u_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
`default_nettype wire
